/* rtl/core/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the per-channel sliding median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW  = 11;
	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 16;

	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W     = $clog2(MAX_WINDOW);
	localparam int CNT_W     = $clog2(MAX_WINDOW);
	localparam int WIDTH_W   = 4;
	localparam int CFG_IDX_W = CH_W;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(5);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CH_W-1:0]               chan_t;
	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [CNT_W-1:0]              cnt_t;
	typedef logic [WIDTH_W-1:0]            width_t;

	// value circulating around the cell ring
	typedef struct packed {
		sample_t val;
		idx_t    idx;
		logic    en;
	} travel_t;

	// control broadcast to every cell
	typedef struct packed {
		logic    load;
		logic    wr;
		logic    shift;
		chan_t   ch;
		idx_t    pos;
		sample_t sample;
		width_t  width;
		cnt_t    rank;
	} cell_ctl_t;

endpackage

/* rtl/core/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// One window slot: holds the slot's sample for every channel and ranks the
// slot's value against the values circulating through the ring.
// ----------------------------------------------------------------------------
module swm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  swm_pkg::cell_ctl_t ctl,
	input  swm_pkg::idx_t      cell_idx,
	input  swm_pkg::travel_t   trav_in,
	output swm_pkg::travel_t   trav_out,
	output swm_pkg::sample_t   value,
	output logic               hit
);
	import swm_pkg::*;

	sample_t store_q [CHANNELS];
	sample_t a_q;
	logic    en_q;
	travel_t trav_q;
	cnt_t    cnt_q;

	logic    wr_here;
	sample_t new_val;
	logic    en_new;
	logic    below;

	assign wr_here = ctl.load && ctl.wr && (ctl.pos == cell_idx);
	assign new_val = wr_here ? ctl.sample : store_q[ctl.ch];
	assign en_new  = (32'(cell_idx) < 32'(ctl.width));
	assign below   = trav_q.en && en_q &&
		((trav_q.val < a_q) || ((trav_q.val == a_q) && (trav_q.idx < cell_idx)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				store_q[c] <= '0;
			end
		end else if (wr_here) begin
			store_q[ctl.ch] <= ctl.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			en_q   <= 1'b0;
			trav_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.load) begin
			a_q    <= new_val;
			en_q   <= en_new;
			trav_q <= '{val: new_val, idx: cell_idx, en: en_new};
			cnt_q  <= '0;
		end else if (ctl.shift) begin
			if (below) begin
				cnt_q <= cnt_q + cnt_t'(1);
			end
			trav_q <= trav_in;
		end
	end

	assign trav_out = trav_q;
	assign value    = a_q;
	assign hit      = en_q && (cnt_q == ctl.rank);

endmodule

/* rtl/core/sliding_window_median_top.sv */
// An item is ranked by one full rotation of the ring of window cells, and no new
// item is taken until that item's result has been registered for output.
// A new item is taken while the previous result waits in the output register.
// Reset: asynchronous, active low; clears all samples and write positions,
// sets both window widths to 5.
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Per-channel sliding median filter built from a ring of ranking cells.
// ----------------------------------------------------------------------------
module sliding_window_median_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [swm_pkg::SAMPLE_BITS-1:0] s_axis_tdata,  // [15:0] sample
	input  logic [swm_pkg::CH_W-1:0]    s_axis_tuser,      // [0] channel
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [swm_pkg::SAMPLE_BITS-1:0] m_axis_tdata,  // [15:0] median
	output logic [swm_pkg::CH_W-1:0]    m_axis_tuser,      // [0] channel_out
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [swm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swm_pkg::WIDTH_W-1:0] cfg_data
);
	import swm_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t    state_q;
	cnt_t      step_q;
	width_t    width_q [CHANNELS];
	idx_t      wp_q    [CHANNELS];
	chan_t     ch_q;
	width_t    w_cur_q;
	logic      ok_q;
	logic      out_valid_q;
	sample_t   out_data_q;
	chan_t     out_ch_q;

	logic      s_accept;
	chan_t     in_ch;
	width_t    w_in;
	logic      ok_in;
	logic [IDX_W:0] pos_inc;
	idx_t      pos_next;
	cell_ctl_t ctl;
	travel_t   trav  [MAX_WINDOW];
	sample_t   vals  [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] hits;
	sample_t   median;
	logic      out_free;

	assign s_accept  = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_ch     = s_axis_tuser;
	assign w_in      = width_q[in_ch];
	assign ok_in     = (w_in != '0) && (32'(w_in) < MAX_WINDOW);
	assign pos_inc   = {1'b0, wp_q[in_ch]} + (IDX_W+1)'(1);
	assign pos_next  = (32'(pos_inc) >= 32'(w_in)) ? '0 : pos_inc[IDX_W-1:0];
	assign out_free  = !out_valid_q || m_axis_tready;

	always_comb begin
		ctl.load   = s_accept;
		ctl.wr     = ok_in;
		ctl.shift  = (state_q == ST_RUN);
		ctl.ch     = in_ch;
		ctl.pos    = pos_next;
		ctl.sample = sample_t'(s_axis_tdata);
		ctl.width  = w_in;
		ctl.rank   = cnt_t'(w_cur_q >> 1);
	end

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		swm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cell_idx (IDX_W'(k)),
			.trav_in  (trav[(k + 1) % MAX_WINDOW]),
			.trav_out (trav[k]),
			.value    (vals[k]),
			.hit      (hits[k])
		);
	end

	always_comb begin
		median = '0;
		for (int k = 0; k < MAX_WINDOW; k++) begin
			if (hits[k]) begin
				median = median | vals[k];
			end
		end
	end

	// configuration and write positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				width_q[c] <= WIDTH_RESET;
				wp_q[c]    <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				width_q[cfg_index] <= cfg_data;
			end
			if (s_accept && ok_in) begin
				wp_q[in_ch] <= pos_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			ch_q        <= '0;
			w_cur_q     <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_ch_q    <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						ch_q    <= in_ch;
						w_cur_q <= w_in;
						ok_q    <= ok_in;
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (32'(step_q) == MAX_WINDOW - 1) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + cnt_t'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= ok_q ? median : '0;
						out_ch_q    <= ch_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ch_q;

endmodule

/* rtl/core/swm_checker.sv */
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the sliding median filter, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [swm_pkg::CH_W-1:0]    s_axis_tuser,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [swm_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
	input logic [swm_pkg::CH_W-1:0]    m_axis_tuser
);
	import swm_pkg::*;

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output transaction changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> ##MAX_WINDOW !s_axis_tready)
		else $error("input taken while ranking ring busy");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_acc, MAX_WINDOW + 2))
		else $error("result without matching input transaction");

	a_chan_echo: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> m_axis_tuser == $past(s_axis_tuser, MAX_WINDOW + 2))
		else $error("result channel does not match input channel");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (.*);
